// File: rtl/stp_pkg.sv
// Shared types, codes and constants of the trapezoidal step-pulse generator.
package stp_pkg;

  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;
  localparam int COUNT_W     = 32;
  localparam int HP_W        = 19;
  localparam int ACC_W       = 20;
  localparam int SPEED_W     = 16;
  localparam int MHP_W       = 8;

  localparam logic [HP_W-1:0] HALF_PERIOD_NUM = 19'd500000;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 16'd20000;
  localparam logic [ACC_W-1:0]   DEF_ACCEL_RST   = 20'd2000;
  localparam logic [SPEED_W-1:0] START_SPEED_RST = 16'd50;
  localparam logic [MHP_W-1:0]   MIN_HP_RST      = 8'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_DEF_ACCEL   = 2'd1,
    REG_START_SPEED = 2'd2,
    REG_MIN_HP      = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CMP, S_SQ, S_SQF, S_DLD, S_DDV, S_UPD, S_HLD, S_HDV, S_HST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic mul_go;
    logic des_goal;
    logic sq_load;
    logic sq_step;
    logic des_sqrt;
    logic dv_load_dlt;
    logic dv_load_hp;
    logic dv_step;
    logic spd_upd;
    logic hp_store;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic calc;
    logic start_ok;
    logic sq_skip;
    logic sq_done;
    logic dv_done;
  } dp_stat_t;

endpackage

// File: rtl/stp_ctl.sv
// Controller state machine that sequences the per-step speed and period math.
module stp_ctl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  stp_pkg::dp_stat_t stat,
  output stp_pkg::ctl_cmd_t cmd
);
  import stp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = stat.out_free;
        cmd.take = s_tvalid && stat.out_free;
        if (cmd.take) begin
          if (stat.calc) begin
            state_next = S_MUL;
          end else if (stat.start_ok) begin
            state_next = S_HLD;
          end
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.sq_skip) begin
          cmd.des_goal = 1'b1;
          state_next   = S_DLD;
        end else begin
          cmd.sq_load = 1'b1;
          state_next  = S_SQ;
        end
      end
      S_SQ: begin
        if (stat.sq_done) begin
          state_next = S_SQF;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_SQF: begin
        cmd.des_sqrt = 1'b1;
        state_next   = S_DLD;
      end
      S_DLD: begin
        cmd.dv_load_dlt = 1'b1;
        state_next      = S_DDV;
      end
      S_DDV: begin
        if (stat.dv_done) begin
          state_next = S_UPD;
        end else begin
          cmd.dv_step = 1'b1;
        end
      end
      S_UPD: begin
        cmd.spd_upd = 1'b1;
        state_next  = S_HLD;
      end
      S_HLD: begin
        cmd.dv_load_hp = 1'b1;
        state_next     = S_HDV;
      end
      S_HDV: begin
        if (stat.dv_done) begin
          state_next = S_HST;
        end else begin
          cmd.dv_step = 1'b1;
        end
      end
      S_HST: begin
        cmd.hp_store = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/stp_dp.sv
// Datapath: move state, configuration, result register, sqrt and divide units.
module stp_dp #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int STEP_BITS       = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [stp_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [stp_pkg::CMD_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stp_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  input  logic [stp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  stp_pkg::ctl_cmd_t                 cmd,
  output stp_pkg::dp_stat_t                 stat
);
  import stp_pkg::*;

  localparam int F     = SPEED_FRAC_BITS;
  localparam int SB    = STEP_BITS;
  localparam int SPD_W = SPEED_W + F;
  localparam int XW    = ACC_W + 1 + SB;
  localparam int CW    = (XW > 32) ? XW : 32;
  localparam int SQ_R  = SPEED_W + F;
  localparam int SQ_W  = 2 * SQ_R;
  localparam int SQ_CW = $clog2(SQ_R + 1);
  localparam int DV_N  = ACC_W + 2 * F;
  localparam int DV_CW = $clog2(DV_N + 1);
  localparam logic [SPD_W-1:0] SPEED_ONE = SPD_W'(1) << F;

  // Configuration.
  logic [SPEED_W-1:0] max_speed, start_speed;
  logic [ACC_W-1:0]   default_accel;
  logic [MHP_W-1:0]   min_half_period;

  // Move state.
  logic             moving, pulse_level, dir_level, enable_level;
  logic [SB-1:0]    steps_made, steps_goal;
  logic [SPD_W-1:0] speed_now, desired;
  logic [SPEED_W-1:0] speed_goal;
  logic [ACC_W-1:0] accel_now;
  logic [HP_W-1:0]  half_period, tick_count;

  logic             moving_next, pulse_level_next, dir_level_next, enable_level_next;
  logic [SB-1:0]    steps_made_next, steps_goal_next;
  logic [SPD_W-1:0] speed_start;
  logic [SPEED_W-1:0] speed_goal_next;
  logic [ACC_W-1:0] accel_now_next;
  logic [HP_W-1:0]  tick_count_next;
  logic             shown;
  status_t          status;

  // Item fields.
  cmd_t             in_cmd;
  logic [SB-1:0]    in_steps;
  logic             in_fwd;
  logic [SPEED_W-1:0] in_speed;
  logic [ACC_W-1:0] in_accel;

  logic [HP_W-1:0]  tick_inc;
  logic [SB-1:0]    steps_inc;
  logic             fire, rise, last, start_ok;
  logic [SPEED_W-1:0] cap, cold;

  assign in_cmd   = cmd_t'(s_tuser);
  assign in_steps = s_tdata[SB-1:0];
  assign in_fwd   = s_tdata[32];
  assign in_speed = s_tdata[48:33];
  assign in_accel = s_tdata[68:49];

  assign tick_inc  = tick_count + 1'b1;
  assign steps_inc = steps_made + 1'b1;
  assign fire      = moving && (tick_inc >= half_period);
  assign rise      = fire && !pulse_level;
  assign last      = steps_inc >= steps_goal;
  assign cap       = (start_speed != '0) ? start_speed : 16'd1;
  assign cold      = (in_speed < cap) ? in_speed : cap;

  always_comb begin
    moving_next       = moving;
    pulse_level_next  = pulse_level;
    dir_level_next    = dir_level;
    enable_level_next = enable_level;
    steps_made_next   = steps_made;
    steps_goal_next   = steps_goal;
    speed_goal_next   = speed_goal;
    accel_now_next    = accel_now;
    tick_count_next   = tick_count;
    speed_start       = {cold, {F{1'b0}}};
    status            = ST_OK;
    start_ok          = 1'b0;
    shown             = pulse_level;
    unique case (in_cmd)
      CMD_TICK: begin
        if (moving) begin
          tick_count_next = fire ? '0 : tick_inc;
          if (fire) begin
            pulse_level_next = !pulse_level;
            shown            = !pulse_level;
            if (rise) begin
              steps_made_next = steps_inc;
              if (last) begin
                moving_next      = 1'b0;
                pulse_level_next = 1'b0;
              end
            end
          end
        end
      end
      CMD_START: begin
        if (moving) begin
          status = ST_BUSY;
        end else if (in_steps == '0) begin
          status = ST_ZERO;
        end else if (in_speed == '0 || in_speed > max_speed) begin
          status = ST_RANGE;
        end else begin
          start_ok          = 1'b1;
          dir_level_next    = in_fwd;
          enable_level_next = 1'b0;
          pulse_level_next  = 1'b0;
          steps_made_next   = '0;
          steps_goal_next   = in_steps;
          speed_goal_next   = in_speed;
          accel_now_next    = (in_accel != '0) ? in_accel : default_accel;
          tick_count_next   = '0;
          moving_next       = 1'b1;
          shown             = 1'b0;
        end
      end
      CMD_STOP: begin
        moving_next       = 1'b0;
        pulse_level_next  = 1'b0;
        enable_level_next = 1'b1;
        shown             = 1'b0;
      end
      default: ;
    endcase
  end

  // Multiply stage of the sqrt bound.
  logic [SB-1:0]  remaining;
  logic [XW-1:0]  x_reg;
  logic [31:0]    g2;
  logic [SPD_W-1:0] goal_q;

  assign remaining = steps_goal - steps_made;
  assign goal_q    = {speed_goal, {F{1'b0}}};

  // Bit-pair square root.
  logic [SQ_W-1:0]  sq_rad;
  logic [SQ_R+1:0]  sq_rem;
  logic [SQ_R-1:0]  sq_root;
  logic [SQ_CW-1:0] sq_cnt;
  logic [SQ_R+3:0]  sq_try, sq_trial;

  assign sq_try   = {sq_rem, sq_rad[SQ_W-1 -: 2]};
  assign sq_trial = (SQ_R+4)'({sq_root, 2'b01});

  // Restoring divider shared by the speed increment and the half period.
  logic [DV_N-1:0]  dv_q;
  logic [SPD_W-1:0] dv_r, dv_d, spd_eff;
  logic [DV_CW-1:0] dv_cnt;
  logic [SPD_W:0]   dv_try;

  assign dv_try  = {dv_r, dv_q[DV_N-1]};
  assign spd_eff = (speed_now == '0) ? SPEED_ONE : speed_now;

  // Speed update toward the desired speed.
  logic [SPD_W-1:0] spd_new, spd_diff;
  logic [HP_W-1:0]  hp_quo, hp_new;

  always_comb begin
    spd_new  = spd_eff;
    spd_diff = '0;
    if (spd_eff < desired) begin
      spd_diff = desired - spd_eff;
      spd_new  = (DV_N'(spd_diff) > dv_q) ? spd_eff + SPD_W'(dv_q) : desired;
    end else if (spd_eff > desired) begin
      spd_diff = spd_eff - desired;
      spd_new  = (DV_N'(spd_diff) > dv_q) ? spd_eff - SPD_W'(dv_q) : desired;
    end
    if (spd_new < SPEED_ONE) begin
      spd_new = SPEED_ONE;
    end
  end

  assign hp_quo = dv_q[HP_W-1:0];
  assign hp_new = (hp_quo < HP_W'(min_half_period)) ? HP_W'(min_half_period) : hp_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed       <= MAX_SPEED_RST;
      default_accel   <= DEF_ACCEL_RST;
      start_speed     <= START_SPEED_RST;
      min_half_period <= MIN_HP_RST;
      moving          <= 1'b0;
      pulse_level     <= 1'b0;
      dir_level       <= 1'b0;
      enable_level    <= 1'b1;
      steps_made      <= '0;
      steps_goal      <= '0;
      speed_now       <= '0;
      speed_goal      <= '0;
      accel_now       <= '0;
      half_period     <= '0;
      tick_count      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MAX_SPEED:   max_speed       <= cfg_data[SPEED_W-1:0];
          REG_DEF_ACCEL:   default_accel   <= cfg_data;
          REG_START_SPEED: start_speed     <= cfg_data[SPEED_W-1:0];
          REG_MIN_HP:      min_half_period <= cfg_data[MHP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        moving       <= moving_next;
        pulse_level  <= pulse_level_next;
        dir_level    <= dir_level_next;
        enable_level <= enable_level_next;
        steps_made   <= steps_made_next;
        steps_goal   <= steps_goal_next;
        speed_goal   <= speed_goal_next;
        accel_now    <= accel_now_next;
        tick_count   <= tick_count_next;
        if (start_ok) begin
          speed_now <= speed_start;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.spd_upd) begin
        speed_now <= spd_new;
      end
      if (cmd.hp_store) begin
        half_period <= hp_new;
      end
    end
  end

  // Result register, and the arithmetic registers, which need no reset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      m_tdata <= {2'b00, status, 32'(steps_made_next), moving_next,
                  enable_level_next, dir_level_next, shown};
    end
    if (cmd.mul_go) begin
      x_reg <= XW'({accel_now, 1'b0}) * XW'(remaining);
      g2    <= 32'(speed_goal) * 32'(speed_goal);
    end
    if (cmd.des_goal) begin
      desired <= goal_q;
    end
    if (cmd.des_sqrt) begin
      desired <= (sq_root < goal_q) ? sq_root : goal_q;
    end
    if (cmd.sq_load) begin
      sq_rad  <= {32'(x_reg), {(2 * F){1'b0}}};
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= SQ_CW'(SQ_R);
    end else if (cmd.sq_step) begin
      sq_rad <= sq_rad << 2;
      sq_cnt <= sq_cnt - 1'b1;
      if (sq_try >= sq_trial) begin
        sq_rem  <= (SQ_R+2)'(sq_try - sq_trial);
        sq_root <= {sq_root[SQ_R-2:0], 1'b1};
      end else begin
        sq_rem  <= (SQ_R+2)'(sq_try);
        sq_root <= {sq_root[SQ_R-2:0], 1'b0};
      end
    end
    if (cmd.dv_load_dlt) begin
      dv_q   <= {accel_now, {(2 * F){1'b0}}};
      dv_r   <= '0;
      dv_d   <= spd_eff;
      dv_cnt <= DV_CW'(DV_N);
    end else if (cmd.dv_load_hp) begin
      dv_q   <= DV_N'(HALF_PERIOD_NUM) << F;
      dv_r   <= '0;
      dv_d   <= spd_eff;
      dv_cnt <= DV_CW'(DV_N);
    end else if (cmd.dv_step) begin
      dv_cnt <= dv_cnt - 1'b1;
      if (dv_try >= {1'b0, dv_d}) begin
        dv_r <= SPD_W'(dv_try - {1'b0, dv_d});
        dv_q <= {dv_q[DV_N-2:0], 1'b1};
      end else begin
        dv_r <= dv_try[SPD_W-1:0];
        dv_q <= {dv_q[DV_N-2:0], 1'b0};
      end
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.calc     = (in_cmd == CMD_TICK) && rise && !last;
  assign stat.start_ok = start_ok;
  assign stat.sq_skip  = CW'(x_reg) >= CW'(g2);
  assign stat.sq_done  = (sq_cnt == '0);
  assign stat.dv_done  = (dv_cnt == '0);

endmodule

// File: rtl/stepper_trapezoid_pulse_gen.sv
// Top level of the trapezoidal step-pulse generator.
// Every command or tick is answered by one result, registered in the cycle
// after its transfer. A tick that raises the pulse line on a step other than
// the last starts the speed update: a multiply, a compare, a bit-pair square
// root and a step to pick the bound when the distance bound applies, and two
// passes of the shared restoring divider, each a load, the divide steps and a
// closing step. Such a tick holds off the input until that work is done. An
// accepted start takes one divider pass to set its first half period. Other
// items need no further work. No new item is taken while that work runs;
// configuration writes are taken always.
module stepper_trapezoid_pulse_gen #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int STEP_BITS       = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // step_count[31:0], forward[32], req_speed[48:33], req_accel[68:49], zero
  input  logic [stp_pkg::IN_TDATA_W-1:0]    s_tdata,
  // cmd[1:0]
  input  logic [stp_pkg::CMD_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pulse[0], direction[1], enable_n[2], busy_res[3], done_count[35:4],
  // status[37:36], zero
  output logic [stp_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import stp_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  stp_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stp_dp #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .STEP_BITS       (STEP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/stp_chk.sv
// Port-level checker for the step-pulse generator, bound to the top level.
module stp_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [stp_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import stp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every transfer in yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // A running move always has the driver enabled.
  a_busy_enabled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("move in progress with driver off");

  // A start refused as busy shows the move that was already running.
  a_refuse_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[37:36] == ST_BUSY) |-> m_tdata[3])
    else $error("busy refusal while idle");

endmodule

bind stepper_trapezoid_pulse_gen stp_chk u_stp_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
